// ===== src/eeprom_word_access_sequencer_assert.svh =====
// Assertion macros used by the sequencer control file (ewas_ctrl).
`ifndef EEPROM_WORD_ACCESS_SEQUENCER_ASSERT_SVH
`define EEPROM_WORD_ACCESS_SEQUENCER_ASSERT_SVH

`ifndef SYNTHESIS
`define EWAS_ASSERT(lbl, clk, rstn, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
		else $error("sequencer assertion failed");
`define EWAS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("sequencer assertion failed");
`else
`define EWAS_ASSERT(lbl, clk, rstn, prop)
`define EWAS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`endif

`endif

// ===== src/ewas_pkg.sv =====
package ewas_pkg;

	localparam int RING_DEPTH_DEF = 16;

	localparam logic [7:0] DEVICE_BASE = 8'h50;
	localparam logic [7:0] TIMEOUT_RST = 8'd30;

	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;

	localparam logic [1:0] BUS_OK   = 2'd2;
	localparam logic [1:0] BUS_FAIL = 2'd3;

	localparam logic [1:0] KIND_ACCEPT = 2'd0;
	localparam logic [1:0] KIND_REFUSE = 2'd1;
	localparam logic [1:0] KIND_CMD    = 2'd2;
	localparam logic [1:0] KIND_DONE   = 2'd3;

	localparam logic [1:0] PH_NEW        = 2'd0;
	localparam logic [1:0] PH_READ       = 2'd1;
	localparam logic [1:0] PH_VERIFY     = 2'd2;
	localparam logic [1:0] PH_WRITE      = 2'd3;

	localparam logic [2:0] WCOUNT_ADDR = 3'd2;
	localparam logic [2:0] WCOUNT_DATA = 3'd6;
	localparam logic [2:0] RCOUNT_WORD = 3'd4;

	typedef struct packed {
		logic [1:0]  bus;
		logic [2:0]  chip;
		logic [15:0] addr;
		logic [31:0] data;
		logic        is_write;
		logic [7:0]  tag;
	} req_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  bus;
		logic [7:0]  device_byte;
		logic [15:0] word_address;
		logic [2:0]  write_count;
		logic [2:0]  read_count;
		logic [31:0] payload;
		logic [7:0]  tag;
		logic        failed;
	} res_t;

	function automatic logic [7:0] device_byte(input logic [2:0] chip);
		logic [7:0] base;
		base = DEVICE_BASE | {5'd0, chip};
		return {base[6:0], 1'b0};
	endfunction

endpackage

// ===== src/eeprom_word_access_sequencer.sv =====
// channel | direction | handshake            | content
// in      | input     | in_valid / in_stall   | operation, request fields, bus status
// out     | output    | out_valid / out_stall | result kind, command fields, done report
// cfg     | input     | cfg_valid / cfg_ready | timeout_ticks
//
// A queue request is accepted, its result registered, then moved to the output register.
// A service tick does a synchronous read of the front entry, then a decision, and when it
// gives a result, a move of that result to the output register. A result moves on only when
// the output register is empty or transfers, and the input stalls until it has moved.
// Reset clears the ring pointers, phase, wait count and valid flags; timeout is 30.
// Memory contents are not cleared; entries are only read after they are written.
module eeprom_word_access_sequencer import ewas_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [1:0]  bus_id,
	input  logic [2:0]  chip_select,
	input  logic [15:0] word_address,
	input  logic [31:0] write_data,
	input  logic [7:0]  request_tag,
	input  logic [1:0]  bus_status,
	input  logic [31:0] read_data,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  result_kind,
	output logic [1:0]  cmd_bus,
	output logic [7:0]  cmd_device_byte,
	output logic [15:0] cmd_word_address,
	output logic [2:0]  cmd_write_count,
	output logic [2:0]  cmd_read_count,
	output logic [31:0] payload,
	output logic [7:0]  done_tag,
	output logic        done_failed
);

	logic [7:0] timeout_q;
	logic       out_valid_q;
	res_t       out_q;
	logic       res_valid;
	res_t       res;
	logic       res_take;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_valid && cfg_ready) begin
			timeout_q <= cfg_data;
		end
	end

	ewas_ctrl #(
		.RING_DEPTH(RING_DEPTH)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.operation   (operation),
		.bus_id      (bus_id),
		.chip_select (chip_select),
		.word_address(word_address),
		.write_data  (write_data),
		.request_tag (request_tag),
		.bus_status  (bus_status),
		.read_data   (read_data),
		.timeout     (timeout_q),
		.res_valid   (res_valid),
		.res         (res),
		.res_take    (res_take)
	);

	assign res_take = res_valid & (~out_valid_q | ~out_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_q <= res;
		end
	end

	assign out_valid        = out_valid_q;
	assign result_kind      = out_q.kind;
	assign cmd_bus          = out_q.bus;
	assign cmd_device_byte  = out_q.device_byte;
	assign cmd_word_address = out_q.word_address;
	assign cmd_write_count  = out_q.write_count;
	assign cmd_read_count   = out_q.read_count;
	assign payload          = out_q.payload;
	assign done_tag         = out_q.tag;
	assign done_failed      = out_q.failed;

endmodule

// ===== src/ewas_req_ram.sv =====
module ewas_req_ram #(
	parameter int DEPTH = 16,
	parameter int WIDTH = 62
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== src/ewas_ctrl.sv =====
`include "eeprom_word_access_sequencer_assert.svh"

module ewas_ctrl import ewas_pkg::*; #(
	parameter int RING_DEPTH = RING_DEPTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  operation,
	input  logic [1:0]  bus_id,
	input  logic [2:0]  chip_select,
	input  logic [15:0] word_address,
	input  logic [31:0] write_data,
	input  logic [7:0]  request_tag,
	input  logic [1:0]  bus_status,
	input  logic [31:0] read_data,
	input  logic [7:0]  timeout,
	output logic        res_valid,
	output res_t        res,
	input  logic        res_take
);

	localparam int PW = $clog2(RING_DEPTH);
	localparam int CW = $clog2(RING_DEPTH + 1);
	localparam logic S_IDLE = 1'b0;
	localparam logic S_LOOK = 1'b1;

	logic          state_q;
	logic [PW-1:0] head_q;
	logic [PW-1:0] tail_q;
	logic [CW-1:0] count_q;
	logic [1:0]    phase_q;
	logic [7:0]    wait_q;
	logic          res_pend_q;
	res_t          res_q;
	logic [1:0]    status_s1;
	logic [31:0]   rdata_s1;

	logic          accept;
	logic          is_req;
	logic          full;
	logic          wr_en;
	logic          rd_en;
	req_t          wr_entry;
	logic [$bits(req_t)-1:0] rd_word;
	req_t          entry;
	res_t          enq_res;
	res_t          lk_res;
	logic          lk_emit;
	logic          lk_pop;
	logic [1:0]    nxt_phase;
	logic [7:0]    nxt_wait;
	logic          do_fin;
	logic          do_pend;
	logic          fin_fail;
	logic [31:0]   fin_payload;

	function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
		return (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	assign in_stall = (state_q != S_IDLE) | res_pend_q;
	assign accept   = in_valid & ~in_stall;
	assign is_req   = (operation == OP_READ) || (operation == OP_WRITE);
	assign full     = (count_q == CW'(RING_DEPTH));
	assign wr_en    = accept & is_req & ~full;
	assign rd_en    = accept & (operation == OP_TICK) & (count_q != '0);

	always_comb begin
		wr_entry.bus      = bus_id;
		wr_entry.chip     = chip_select;
		wr_entry.addr     = word_address;
		wr_entry.data     = (operation == OP_WRITE) ? write_data : 32'd0;
		wr_entry.is_write = (operation == OP_WRITE);
		wr_entry.tag      = request_tag;
	end

	ewas_req_ram #(
		.DEPTH(RING_DEPTH),
		.WIDTH($bits(req_t))
	) u_ram (
		.clk    (clk),
		.wr_en  (wr_en),
		.wr_addr(tail_q),
		.wr_data(wr_entry),
		.rd_en  (rd_en),
		.rd_addr(head_q),
		.rd_data(rd_word)
	);

	assign entry = req_t'(rd_word);

	always_comb begin
		enq_res      = '0;
		enq_res.kind = full ? KIND_REFUSE : KIND_ACCEPT;
		enq_res.tag  = request_tag;
	end

	always_comb begin
		lk_res      = '0;
		lk_emit     = 1'b0;
		lk_pop      = 1'b0;
		nxt_phase   = phase_q;
		nxt_wait    = wait_q;
		do_fin      = 1'b0;
		do_pend     = 1'b0;
		fin_fail    = 1'b0;
		fin_payload = 32'd0;
		case (phase_q)
			PH_NEW: begin
				lk_emit             = 1'b1;
				lk_res.kind         = KIND_CMD;
				lk_res.bus          = entry.bus;
				lk_res.device_byte  = device_byte(entry.chip);
				lk_res.word_address = entry.addr;
				lk_res.write_count  = WCOUNT_ADDR;
				lk_res.read_count   = RCOUNT_WORD;
				nxt_wait            = 8'd0;
				nxt_phase           = entry.is_write ? PH_VERIFY : PH_READ;
			end
			PH_READ: begin
				if (status_s1 == BUS_OK) begin
					do_fin      = 1'b1;
					fin_payload = rdata_s1;
				end else if (status_s1 == BUS_FAIL) begin
					do_fin   = 1'b1;
					fin_fail = 1'b1;
				end else begin
					do_pend = 1'b1;
				end
			end
			PH_VERIFY: begin
				if (status_s1 == BUS_OK) begin
					if (rdata_s1 == entry.data) begin
						do_fin = 1'b1;
					end else begin
						lk_emit             = 1'b1;
						lk_res.kind         = KIND_CMD;
						lk_res.bus          = entry.bus;
						lk_res.device_byte  = device_byte(entry.chip);
						lk_res.word_address = entry.addr;
						lk_res.write_count  = WCOUNT_DATA;
						lk_res.payload      = entry.data;
						nxt_wait            = 8'd0;
						nxt_phase           = PH_WRITE;
					end
				end else if (status_s1 == BUS_FAIL) begin
					do_fin   = 1'b1;
					fin_fail = 1'b1;
				end else begin
					do_pend = 1'b1;
				end
			end
			PH_WRITE: begin
				if (status_s1 == BUS_OK) begin
					do_fin = 1'b1;
				end else if (status_s1 == BUS_FAIL) begin
					do_fin   = 1'b1;
					fin_fail = 1'b1;
				end else begin
					do_pend = 1'b1;
				end
			end
			default: begin
				do_pend = 1'b1;
			end
		endcase
		if (do_pend) begin
			if (wait_q >= timeout) begin
				do_fin   = 1'b1;
				fin_fail = 1'b1;
			end else begin
				nxt_wait = wait_q + 8'd1;
			end
		end
		if (do_fin) begin
			lk_emit        = 1'b1;
			lk_pop         = 1'b1;
			nxt_phase      = PH_NEW;
			nxt_wait       = 8'd0;
			lk_res         = '0;
			lk_res.kind    = KIND_DONE;
			lk_res.tag     = entry.tag;
			lk_res.failed  = fin_fail;
			lk_res.payload = fin_fail ? 32'd0 : fin_payload;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_IDLE;
			head_q     <= '0;
			tail_q     <= '0;
			count_q    <= '0;
			phase_q    <= PH_NEW;
			wait_q     <= 8'd0;
			res_pend_q <= 1'b0;
		end else begin
			if (res_take) begin
				res_pend_q <= 1'b0;
			end
			if (accept && is_req) begin
				res_pend_q <= 1'b1;
				if (!full) begin
					tail_q  <= wrap_inc(tail_q);
					count_q <= count_q + 1'b1;
				end
			end else if (rd_en) begin
				state_q <= S_LOOK;
			end
			if (state_q == S_LOOK) begin
				state_q <= S_IDLE;
				phase_q <= nxt_phase;
				wait_q  <= nxt_wait;
				if (lk_emit) begin
					res_pend_q <= 1'b1;
				end
				if (lk_pop) begin
					head_q  <= wrap_inc(head_q);
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && is_req) begin
			res_q <= enq_res;
		end else if (state_q == S_LOOK && lk_emit) begin
			res_q <= lk_res;
		end
		if (rd_en) begin
			status_s1 <= bus_status;
			rdata_s1  <= read_data;
		end
	end

	assign res_valid = res_pend_q;
	assign res       = res_q;

	`EWAS_ASSERT(a_count_bound, clk, arst_n, count_q <= CW'(RING_DEPTH))
	`EWAS_ASSERT_IMPL(a_pend_idle, clk, arst_n, res_pend_q, state_q == S_IDLE)
	`EWAS_ASSERT_IMPL(a_look_nonempty, clk, arst_n, state_q == S_LOOK, count_q != '0)

endmodule
